/* src/vroq_pkg.sv */
// Shared types, constants and helper functions for the voxel ray occlusion query core.
`default_nettype none
package vroq_pkg;

  localparam int POINT_W = 20;          // signed Q12.8 point field
  localparam int IDX_W   = 6;           // start and hit index fields
  localparam int GSZ_W   = 7;           // grid size register width
  localparam int SIZE_W  = 9;           // clamped grid size, up to 256
  localparam int POS_W   = 12;          // signed voxel position, covers floor of any point
  localparam int DIFF_W  = 21;          // signed ray direction in Q.8
  localparam int AD_W    = 20;          // direction magnitude
  localparam int QUO_W   = 25;          // floor(2^24 / magnitude)
  localparam int TIME_W  = 32;          // unsigned Q16.16 crossing time
  localparam int CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0] TIME_SAT = '1;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE_X = 2'd0,
    REG_GRID_SIZE_Y = 2'd1,
    REG_GRID_SIZE_Z = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  // Axis to step from the three pairwise crossing-time compares.
  function automatic axis_t axis_pick(input logic [2:0] sel);
    axis_t ax;
    case (sel)
      3'd0: ax = AXIS_Z;
      3'd1: ax = AXIS_Y;
      3'd2: ax = AXIS_Z;
      3'd3: ax = AXIS_Y;
      3'd4: ax = AXIS_Z;
      3'd5: ax = AXIS_Z;
      3'd6: ax = AXIS_X;
      3'd7: ax = AXIS_X;
      default: ax = AXIS_Z;
    endcase
    return ax;
  endfunction

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_SAT : s[TIME_W-1:0];
  endfunction

  // Divider handshake toward the sequencer.
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

/* src/vroq_div.sv */
// Shared restoring divider: floor(2^24 / divisor), one quotient bit per cycle.
`default_nettype none
module vroq_div
  import vroq_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [AD_W-1:0] divisor,
  output div_rsp_t             rsp
);

  logic                busy;
  logic [4:0]          cnt;
  logic [AD_W-1:0]     dvs;
  logic [AD_W-1:0]     rem;
  logic [QUO_W-1:0]    quo;
  logic                done;
  logic [AD_W:0]       trial;
  logic                qbit;

  // Dividend is a single one at its top bit.
  always_comb begin
    trial = {rem, (cnt == 5'(QUO_W - 1))};
    qbit  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(QUO_W - 1);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      rem <= qbit ? AD_W'(trial - {1'b0, dvs}) : trial[AD_W-1:0];
      quo <= {quo[QUO_W-2:0], qbit};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

/* src/vroq_mem.sv */
// Single-port voxel count store with registered read data.
`default_nettype none
module vroq_mem #(
  parameter int AW = 18,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* src/voxel_ray_occlusion_query_core.sv */
// Top level of the voxel ray occlusion query core: sequencer, registers and result stage.
//
// Usage: one request channel (in_valid/in_ready) carries mode, start_x/y/z and
// point_x/y/z; one result channel (out_valid/out_ready) returns accepted, hit and
// hit_x/y/z, exactly one result per request. The cfg port (cfg_we, cfg_index,
// cfg_data) sets grid_size_x/y/z; write it only while the core is idle.
// One request is in work at a time; in_ready is high only while the sequencer idles.
// Work per request, paced by the single-port count memory and the shared
// one-bit-per-cycle divider:
//   clear  : 2^(XB+YB+ZB) words (262144 at 64^3), one memory word per cycle
//   insert : read, modify-write, result
//   query  : up to three divisions (one per axis), then per voxel walked
//            one memory read and one compare/step, then the result
// Reset runs the same clearing sweep over the whole memory (262144 words at the
// default sizes) with in_ready low; cfg writes are taken during it.
// When the receiver stalls, the finished result holds in the output register;
// one further request is accepted and worked, and its result waits in the
// sequencer until the output register frees.
`default_nettype none
module voxel_ray_occlusion_query_core
  import vroq_pkg::*;
#(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64,
  parameter int MAX_Z = 64,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [GSZ_W-1:0]          cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                mode,
  input  wire logic [IDX_W-1:0]          start_x,
  input  wire logic [IDX_W-1:0]          start_y,
  input  wire logic [IDX_W-1:0]          start_z,
  input  wire logic signed [POINT_W-1:0] point_x,
  input  wire logic signed [POINT_W-1:0] point_y,
  input  wire logic signed [POINT_W-1:0] point_z,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           accepted,
  output logic                           hit,
  output logic [IDX_W-1:0]               hit_x,
  output logic [IDX_W-1:0]               hit_y,
  output logic [IDX_W-1:0]               hit_z
);

  localparam int XB = $clog2(MAX_X);
  localparam int YB = $clog2(MAX_Y);
  localparam int ZB = $clog2(MAX_Z);
  localparam int AW = XB + YB + ZB;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CLEAR    = 9'b000000010,
    S_INS_RD   = 9'b000000100,
    S_INS_WR   = 9'b000001000,
    S_Q_DSTART = 9'b000010000,
    S_Q_DWAIT  = 9'b000100000,
    S_Q_RD     = 9'b001000000,
    S_Q_CHK    = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  state_t state;

  logic [GSZ_W-1:0] gsz [3];
  logic [SIZE_W-1:0] sz_eff [3];
  logic [SIZE_W-1:0] size [3];

  logic signed [POS_W-1:0] pos [3];
  logic signed [POS_W-1:0] endv [3];
  logic                    neg [3];
  logic [AD_W-1:0]         ad [3];
  logic [TIME_W-1:0]       tn [3];
  logic [TIME_W-1:0]       td [3];
  logic [1:0]              ax_cnt;

  logic [AW-1:0] clr_addr;
  logic          clr_reply;
  logic [AW-1:0] ins_addr;

  logic          r_acc;
  logic          r_hit;

  // Request-time decode.
  logic [IDX_W-1:0]          in_start [3];
  logic signed [POINT_W-1:0] in_pt [3];
  logic signed [POS_W-1:0]   in_v [3];
  logic signed [DIFF_W-1:0]  in_d [3];
  logic                      start_in_grid;
  logic                      ins_in_grid;

  // Walk step logic.
  logic [2:0]              sel;
  axis_t                   ax;
  logic signed [POS_W-1:0] pos_n [3];
  logic [TIME_W-1:0]       tn_n [3];
  logic                    in_bounds;
  logic                    exit_hit;
  logic                    end_hit;

  // Memory port.
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] mem_rdata;

  logic                  div_start;
  logic [AD_W-1:0]       div_divisor;
  div_rsp_t              div_rsp;

  logic                  out_load;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_FINISH) && (!out_valid || out_ready);

  // Clamp each size register to its axis capacity.
  always_comb begin
    sz_eff[0] = ({2'b0, gsz[0]} > SIZE_W'(MAX_X)) ? SIZE_W'(MAX_X) : {2'b0, gsz[0]};
    sz_eff[1] = ({2'b0, gsz[1]} > SIZE_W'(MAX_Y)) ? SIZE_W'(MAX_Y) : {2'b0, gsz[1]};
    sz_eff[2] = ({2'b0, gsz[2]} > SIZE_W'(MAX_Z)) ? SIZE_W'(MAX_Z) : {2'b0, gsz[2]};
  end

  always_comb begin
    in_start[0] = start_x;
    in_start[1] = start_y;
    in_start[2] = start_z;
    in_pt[0]    = point_x;
    in_pt[1]    = point_y;
    in_pt[2]    = point_z;
    start_in_grid = 1'b1;
    ins_in_grid   = 1'b1;
    for (int a = 0; a < 3; a++) begin
      // floor(point / 256) is the integer part of Q12.8
      in_v[a] = in_pt[a][POINT_W-1:8];
      // direction from the voxel centre (index*256 + 128)
      in_d[a] = DIFF_W'(in_pt[a]) - $signed(DIFF_W'({in_start[a], 8'h80}));
      if ({3'b0, in_start[a]} >= size[a] || {3'b0, in_start[a]} >= sz_eff[a]) begin
        start_in_grid = 1'b0;
      end
      if (in_v[a] < 0 || in_v[a] >= $signed({3'b0, sz_eff[a]})) begin
        ins_in_grid = 1'b0;
      end
    end
    // size[] above only narrows when it is stale; the live clamp decides
    if ({3'b0, start_x} < sz_eff[0] && {3'b0, start_y} < sz_eff[1] &&
        {3'b0, start_z} < sz_eff[2]) begin
      start_in_grid = 1'b1;
    end
  end

  // Pick the axis with the earliest crossing and advance it.
  always_comb begin
    sel = {tn[0] < tn[1], tn[0] < tn[2], tn[1] < tn[2]};
    ax  = axis_pick(sel);
    exit_hit = 1'b0;
    in_bounds = 1'b1;
    for (int a = 0; a < 3; a++) begin
      pos_n[a] = pos[a];
      tn_n[a]  = tn[a];
      if (ax == axis_t'(a)) begin
        pos_n[a] = neg[a] ? pos[a] - POS_W'(1) : pos[a] + POS_W'(1);
        tn_n[a]  = sat_add(tn[a], td[a]);
        if (neg[a] ? (pos_n[a] == -POS_W'(1))
                   : (pos_n[a] == $signed({3'b0, size[a]}))) begin
          exit_hit = 1'b1;
        end
      end
      if (pos[a] < 0 || pos[a] >= $signed({3'b0, size[a]})) begin
        in_bounds = 1'b0;
      end
    end
    end_hit = (pos_n[0] == endv[0]) && (pos_n[1] == endv[1]) && (pos_n[2] == endv[2]);
  end

  // Memory port steering.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_addr  = {pos[2][ZB-1:0], pos[1][YB-1:0], pos[0][XB-1:0]};
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      S_INS_RD: begin
        mem_addr = ins_addr;
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_addr  = ins_addr;
        // saturate at the top count
        mem_wdata = (&mem_rdata) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (ax_cnt)
      2'd0: div_divisor = ad[0];
      2'd1: div_divisor = ad[1];
      default: div_divisor = ad[2];
    endcase
    div_start = (state == S_Q_DSTART) && (div_divisor != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gsz[0] <= GSZ_W'(64);
      gsz[1] <= GSZ_W'(64);
      gsz[2] <= GSZ_W'(64);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_SIZE_X: gsz[0] <= cfg_data;
        REG_GRID_SIZE_Y: gsz[1] <= cfg_data;
        REG_GRID_SIZE_Z: gsz[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      ax_cnt    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            // only a query reports acceptance here; an insert sets it on write
            r_acc <= (mode_t'(mode) == MODE_QUERY) && start_in_grid;
            r_hit <= 1'b0;
            for (int a = 0; a < 3; a++) begin
              size[a] <= sz_eff[a];
              pos[a]  <= $signed({6'b0, in_start[a]});
              endv[a] <= in_v[a];
              neg[a]  <= in_d[a][DIFF_W-1];
              ad[a]   <= in_d[a][DIFF_W-1] ? AD_W'(-in_d[a]) : AD_W'(in_d[a]);
            end
            ins_addr <= {in_v[2][ZB-1:0], in_v[1][YB-1:0], in_v[0][XB-1:0]};
            ax_cnt   <= '0;
            case (mode_t'(mode))
              MODE_CLEAR: begin
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              MODE_INSERT: begin
                state <= ins_in_grid ? S_INS_RD : S_FINISH;
              end
              MODE_QUERY: begin
                state <= start_in_grid ? S_Q_DSTART : S_FINISH;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (&clr_addr) begin
            state     <= clr_reply ? S_FINISH : S_IDLE;
            clr_reply <= 1'b0;
          end
        end
        S_INS_RD: begin
          state <= S_INS_WR;
        end
        S_INS_WR: begin
          r_acc <= 1'b1;
          state <= S_FINISH;
        end
        S_Q_DSTART: begin
          if (div_divisor == '0) begin
            // zero direction: never reached
            for (int a = 0; a < 3; a++) begin
              if (ax_cnt == 2'(a)) begin
                tn[a] <= TIME_SAT;
                td[a] <= TIME_SAT;
              end
            end
            ax_cnt <= ax_cnt + 2'd1;
            state  <= (ax_cnt == 2'd2) ? S_Q_RD : S_Q_DSTART;
          end else begin
            state <= S_Q_DWAIT;
          end
        end
        S_Q_DWAIT: begin
          if (div_rsp.done) begin
            for (int a = 0; a < 3; a++) begin
              if (ax_cnt == 2'(a)) begin
                td[a] <= TIME_W'(div_rsp.quotient);
                tn[a] <= TIME_W'(div_rsp.quotient[QUO_W-1:1]);
              end
            end
            ax_cnt <= ax_cnt + 2'd1;
            state  <= (ax_cnt == 2'd2) ? S_Q_RD : S_Q_DSTART;
          end
        end
        S_Q_RD: begin
          state <= in_bounds ? S_Q_CHK : S_FINISH;
        end
        S_Q_CHK: begin
          if (mem_rdata != '0) begin
            r_hit <= 1'b1;
            state <= S_FINISH;
          end else begin
            for (int a = 0; a < 3; a++) begin
              pos[a] <= pos_n[a];
              tn[a]  <= tn_n[a];
            end
            state <= (exit_hit || end_hit) ? S_FINISH : S_Q_RD;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accepted <= r_acc;
      hit      <= r_hit;
      hit_x    <= r_hit ? pos[0][IDX_W-1:0] : '0;
      hit_y    <= r_hit ? pos[1][IDX_W-1:0] : '0;
      hit_z    <= r_hit ? pos[2][IDX_W-1:0] : '0;
    end
  end

  vroq_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (div_divisor),
    .rsp     (div_rsp)
  );

  vroq_mem #(
    .AW (AW),
    .DW (COUNT_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // One request in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  // The voxel under test always lies inside the grid.
  a_check_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == S_Q_CHK |-> (pos[0] >= 0 && pos[1] >= 0 && pos[2] >= 0 &&
                          pos[0] < $signed({3'b0, size[0]}) &&
                          pos[1] < $signed({3'b0, size[1]}) &&
                          pos[2] < $signed({3'b0, size[2]})))
    else $error("walk tests a voxel outside the grid");

  // A new result appears only from the finish step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result raised outside the finish step");

  // Divider completes only while the sequencer waits on it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_Q_DWAIT)
    else $error("divider finished with no one waiting");

endmodule
`default_nettype wire

/* test/voxel_ray_occlusion_query_checker.sv */
// Request/result monitor with an occupancy-grid predictor for the voxel ray occlusion query core.
module voxel_ray_occlusion_query_checker
  import vroq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [GSZ_W-1:0]          cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                mode,
  input  logic [IDX_W-1:0]          start_x,
  input  logic [IDX_W-1:0]          start_y,
  input  logic [IDX_W-1:0]          start_z,
  input  logic signed [POINT_W-1:0] point_x,
  input  logic signed [POINT_W-1:0] point_y,
  input  logic signed [POINT_W-1:0] point_z,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      accepted,
  input  logic                      hit,
  input  logic [IDX_W-1:0]          hit_x,
  input  logic [IDX_W-1:0]          hit_y,
  input  logic [IDX_W-1:0]          hit_z,
  output int                        errors,
  output int                        outstanding,
  output int                        n_results,
  output int                        n_hits
);

  localparam int GRID = 64;
  localparam int CNT_MAX = 65535;
  localparam longint unsigned T_SAT = 64'hFFFF_FFFF;
  localparam int STEP_AXIS [8] = '{2, 1, 2, 1, 2, 2, 0, 0};

  typedef struct packed {
    logic             accepted;
    logic             hit;
    logic [IDX_W-1:0] hx;
    logic [IDX_W-1:0] hy;
    logic [IDX_W-1:0] hz;
  } occl_result_t;

  logic [15:0]  occupancy [0:GRID*GRID*GRID-1];
  logic [6:0]   grid_reg [3];
  occl_result_t pending_results [$];
  bit           rst_cleared;

  function automatic int vox_addr(int x, int y, int z);
    return x + GRID * (y + GRID * z);
  endfunction

  function automatic occl_result_t trace_request(
      logic [1:0] m, logic [IDX_W-1:0] sx, logic [IDX_W-1:0] sy, logic [IDX_W-1:0] sz,
      logic signed [POINT_W-1:0] px, logic signed [POINT_W-1:0] py,
      logic signed [POINT_W-1:0] pz);
    occl_result_t r;
    int lim[3], pos[3], pt[3], endv[3], stp[3], ex[3], cv[3];
    int d, ad, ax;
    longint unsigned tn[3], td[3];
    bit in_grid;
    logic [2:0] sel;
    r = '0;
    for (int a = 0; a < 3; a++) lim[a] = (grid_reg[a] > GRID) ? GRID : int'(grid_reg[a]);
    pos[0] = sx; pos[1] = sy; pos[2] = sz;
    pt[0] = px; pt[1] = py; pt[2] = pz;
    case (mode_t'(m))
      MODE_CLEAR: begin
        for (int i = 0; i < GRID*GRID*GRID; i++) occupancy[i] = '0;
      end
      MODE_INSERT: begin
        in_grid = 1;
        for (int a = 0; a < 3; a++) begin
          cv[a] = pt[a] >>> 8;
          if (cv[a] < 0 || cv[a] >= lim[a]) in_grid = 0;
        end
        if (in_grid) begin
          if (occupancy[vox_addr(cv[0], cv[1], cv[2])] < CNT_MAX)
            occupancy[vox_addr(cv[0], cv[1], cv[2])]++;
          r.accepted = 1;
        end
      end
      MODE_QUERY: begin
        in_grid = 1;
        for (int a = 0; a < 3; a++) begin
          d = pt[a] - (pos[a] * 256 + 128);
          if (pos[a] >= lim[a]) in_grid = 0;
          endv[a] = pt[a] >>> 8;
          stp[a] = (d < 0) ? -1 : 1;
          ex[a] = (d < 0) ? -1 : lim[a];
          ad = (d < 0) ? -d : d;
          tn[a] = (ad == 0) ? T_SAT : (longint'(1) << 23) / ad;
          td[a] = (ad == 0) ? T_SAT : (longint'(1) << 24) / ad;
        end
        if (in_grid) begin
          r.accepted = 1;
          forever begin
            if (pos[0] < 0 || pos[1] < 0 || pos[2] < 0) break;
            if (pos[0] >= lim[0] || pos[1] >= lim[1] || pos[2] >= lim[2]) break;
            if (occupancy[vox_addr(pos[0], pos[1], pos[2])] != 0) begin
              r.hit = 1;
              r.hx = pos[0][5:0];
              r.hy = pos[1][5:0];
              r.hz = pos[2][5:0];
              break;
            end
            sel = {tn[0] < tn[1], tn[0] < tn[2], tn[1] < tn[2]};
            ax = STEP_AXIS[sel];
            pos[ax] += stp[ax];
            tn[ax] = tn[ax] + td[ax];
            if (tn[ax] > T_SAT) tn[ax] = T_SAT;
            if (pos[ax] == ex[ax]) break;
            if (pos[0] == endv[0] && pos[1] == endv[1] && pos[2] == endv[2]) break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    errors = 0;
    outstanding = 0;
    n_results = 0;
    n_hits = 0;
    rst_cleared = 0;
  end

  always @(posedge clk) begin
    occl_result_t got, want;
    if (rst) begin
      if (!rst_cleared) for (int i = 0; i < GRID*GRID*GRID; i++) occupancy[i] = '0;
      rst_cleared = 1;
      for (int a = 0; a < 3; a++) grid_reg[a] = 7'd64;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_GRID_SIZE_X: grid_reg[0] = cfg_data;
          REG_GRID_SIZE_Y: grid_reg[1] = cfg_data;
          REG_GRID_SIZE_Z: grid_reg[2] = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{accepted, hit, hit_x, hit_y, hit_z};
        n_results++;
        if (hit) n_hits++;
        if (pending_results.size() == 0) begin
          if (errors < 10) $display("unexpected result %p", got);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (errors < 10) $display("result mismatch: expected %p, got %p", want, got);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        pending_results = {pending_results,
                           trace_request(mode, start_x, start_y, start_z,
                                         point_x, point_y, point_z)};
    end
    outstanding = pending_results.size();
  end

endmodule

/* test/tb_voxel_ray_occlusion_query_core.sv */
// Stimulus, handshake pacing and verdict for the voxel ray occlusion query core.
module tb_voxel_ray_occlusion_query_core;
  import vroq_pkg::*;

  // Slowest run: reset sweep plus three full clears and ~1150 requests with both
  // sides stalling; keep margin.
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int PHASE_ITEMS = 113;
  localparam int N_PHASES = 10;

  logic                      clk = 0;
  logic                      rst = 1;
  logic                      cfg_we = 0;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_GRID_SIZE_X;
  logic [GSZ_W-1:0]          cfg_data = '0;
  logic                      in_valid = 0;
  logic                      in_ready;
  logic [1:0]                mode = MODE_NONE;
  logic [IDX_W-1:0]          start_x = '0, start_y = '0, start_z = '0;
  logic signed [POINT_W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic                      out_valid;
  logic                      out_ready = 0;
  logic                      accepted, hit;
  logic [IDX_W-1:0]          hit_x, hit_y, hit_z;

  int errors, outstanding, n_results, n_hits;
  int cycles = 0;
  int sent = 0;
  int settings_used = 0;
  bit tx_burst = 0, rx_burst = 0, held_off = 0;
  int grid_lim [3] = '{64, 64, 64};

  // Grid sizes per random phase: default, minimal, zero axis, above the
  // parameter, maximum register value, and a few small shapes.
  logic [6:0] phase_sizes [N_PHASES][3] = '{
    '{7'd8, 7'd8, 7'd8}, '{7'd1, 7'd1, 7'd1}, '{7'd4, 7'd4, 7'd4},
    '{7'd0, 7'd3, 7'd3}, '{7'd100, 7'd2, 7'd64}, '{7'd16, 7'd3, 7'd5},
    '{7'd64, 7'd1, 7'd1}, '{7'd127, 7'd127, 7'd127}, '{7'd6, 7'd0, 7'd9},
    '{7'd64, 7'd64, 7'd64}};

  always #1 clk = ~clk;

  voxel_ray_occlusion_query_core dut (.*);

  voxel_ray_occlusion_query_checker u_checker (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one request after a random gap; hold it until accepted.
  task automatic offer(logic [1:0] m, logic [IDX_W-1:0] sx, logic [IDX_W-1:0] sy,
                       logic [IDX_W-1:0] sz, logic signed [POINT_W-1:0] px,
                       logic signed [POINT_W-1:0] py, logic signed [POINT_W-1:0] pz);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    mode = m; start_x = sx; start_y = sy; start_z = sz;
    point_x = px; point_y = py; point_z = pz;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  // Change a grid size only with the core drained.
  task automatic write_size(cfg_reg_t idx, logic [6:0] val);
    in_valid = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    grid_lim[idx] = (val > 64) ? 64 : int'(val);
  endtask

  function automatic logic signed [POINT_W-1:0] any_point();
    return POINT_W'($urandom);
  endfunction

  // Point inside the grid along one axis when possible, else anything.
  function automatic logic signed [POINT_W-1:0] grid_point(int a);
    if (grid_lim[a] == 0) return any_point();
    return POINT_W'($urandom_range(0, grid_lim[a] * 256 - 1));
  endfunction

  function automatic logic [IDX_W-1:0] grid_start(int a);
    if (grid_lim[a] == 0 || $urandom_range(0, 99) < 15) return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, grid_lim[a] - 1));
  endfunction

  // Ray endpoint: near the grid, far away, or on the start center (zero direction).
  function automatic logic signed [POINT_W-1:0] ray_end(int a, logic [IDX_W-1:0] s);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return POINT_W'($urandom_range(0, (grid_lim[a] + 4) * 256) - 512);
    if (pick < 85) return any_point();
    return POINT_W'(s * 256 + 128);
  endfunction

  task automatic random_request();
    int pick;
    logic [IDX_W-1:0] s [3];
    pick = $urandom_range(0, 99);
    for (int a = 0; a < 3; a++) s[a] = grid_start(a);
    if (pick < 45) begin
      if ($urandom_range(0, 3) != 0)
        offer(MODE_INSERT, s[0], s[1], s[2], grid_point(0), grid_point(1), grid_point(2));
      else
        offer(MODE_INSERT, s[0], s[1], s[2], any_point(), any_point(), any_point());
    end else if (pick < 97) begin
      offer(MODE_QUERY, s[0], s[1], s[2], ray_end(0, s[0]), ray_end(1, s[1]),
            ray_end(2, s[2]));
    end else begin
      offer(MODE_NONE, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
            any_point(), any_point(), any_point());
    end
  endtask

  // Receiver: random stalls, bursts of no stall, and one long hold-off.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held_off && sent >= 300) begin
        held_off = 1;
        out_ready = 0;
        repeat (800) @(negedge clk);
      end
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ready = 0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst = 0;

    // Directed: default 64^3 grid.
    offer(MODE_INSERT, 0, 0, 0, 20'sd0, 20'sd0, 20'sd0);
    offer(MODE_INSERT, 0, 0, 0, 20'sd16383, 20'sd16383, 20'sd16383);
    offer(MODE_INSERT, 0, 0, 0, -20'sd1, 20'sd100, 20'sd100);
    offer(MODE_INSERT, 0, 0, 0, 20'sd100, 20'sd16384, 20'sd100);
    offer(MODE_INSERT, 0, 0, 0, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
    offer(MODE_INSERT, 0, 0, 0, 20'sh80000, 20'sh80000, 20'sh80000);
    offer(MODE_INSERT, 0, 0, 0, 20'sd1408, 20'sd1408, 20'sd1408);
    offer(MODE_INSERT, 0, 0, 0, 20'sd1408, 20'sd1408, 20'sd1408);
    offer(MODE_QUERY, 0, 0, 0, 20'sd16000, 20'sd9000, 20'sd300);
    offer(MODE_QUERY, 20, 20, 20, 20'sd512, 20'sd512, 20'sd512);
    offer(MODE_QUERY, 63, 63, 63, 20'sh80000, 20'sh80000, 20'sh80000);
    offer(MODE_QUERY, 10, 3, 7, 20'sd2688, 20'sd896, 20'sd1920);
    offer(MODE_QUERY, 5, 0, 5, 20'sd1408, 20'sh7FFFF, 20'sd1408);
    offer(MODE_QUERY, 30, 0, 63, 20'sd7808, 20'sh7FFFF, 20'sh80000);
    offer(MODE_NONE, 6'h3F, 6'h2A, 6'h15, 20'sh55555, 20'shAAAAA, 20'sh7FFFF);
    offer(MODE_QUERY, 0, 0, 0, 20'sd16383, 20'sd16383, 20'sd16383);
    offer(MODE_CLEAR, 0, 0, 0, 20'sd0, 20'sd0, 20'sd0);
    offer(MODE_QUERY, 0, 0, 0, 20'sd16383, 20'sd16383, 20'sd16383);
    offer(MODE_INSERT, 0, 0, 0, 20'sd16200, 20'sd16200, 20'sd16200);
    offer(MODE_QUERY, 0, 0, 0, 20'sd16383, 20'sd16383, 20'sd16383);
    settings_used = 1;

    // Random phases, each under its own grid shape.
    for (int p = 0; p < N_PHASES; p++) begin
      write_size(REG_GRID_SIZE_X, phase_sizes[p][0]);
      write_size(REG_GRID_SIZE_Y, phase_sizes[p][1]);
      write_size(REG_GRID_SIZE_Z, phase_sizes[p][2]);
      settings_used++;
      if (p == 3 || p == 7) offer(MODE_CLEAR, 0, 0, 0, any_point(), any_point(), any_point());
      repeat (PHASE_ITEMS) random_request();
    end
    in_valid = 0;

    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("run covered %0d requests over %0d grid settings: %0d results, %0d hits",
             sent, settings_used, n_results, n_hits);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/vroq_pkg.sv
src/vroq_div.sv
src/vroq_mem.sv
src/voxel_ray_occlusion_query_core.sv
test/voxel_ray_occlusion_query_checker.sv
test/tb_voxel_ray_occlusion_query_core.sv
